// ----- hdl/wspr_pkg.sv -----
`timescale 1ns / 1ps
package wspr_pkg;

  localparam int MAX_POINTS = 512;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);

  localparam logic [15:0] MIN_IV_RESET = 16'd10;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_REC    = 3'd1,
    PH_SAVED  = 3'd2,
    PH_LOADED = 3'd3,
    PH_PLAY   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    MD_REC_START  = 3'd0,
    MD_REC_STOP   = 3'd1,
    MD_REC_TICK   = 3'd2,
    MD_PLAY_START = 3'd3,
    MD_PLAY_STOP  = 3'd4,
    MD_PLAY_TICK  = 3'd5,
    MD_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_REC2 = 3'd2,
    S_RD   = 3'd3,
    S_CHK  = 3'd4,
    S_DONE = 3'd5
  } seq_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] gap;
  } point_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    point_t            data;
  } store_wr_t;

endpackage

// ----- hdl/wheel_speed_path_recorder.sv -----
`timescale 1ns / 1ps
// Wheel-speed path recorder and replayer.
// Command channel: an item (in_mode, in_time_now, in_enc_left, in_enc_right)
// is taken at a rising edge with start high and busy low. busy stays high
// while the sequencer works on it.
// Result channel: out_strobe is high for exactly one cycle with the result
// fields; the receiver cannot stall it, it must take the result that cycle.
// Configuration: cfg_valid/cfg_ready write min_interval from cfg_data;
// cfg_ready is always high. Write it only while the block is idle.
// Sequence: each item goes from an execute state to a done state; a recording
// tick that finds room in the store also passes through a write state. A replay
// tick that reads n stored points spends, per point, one state on the registered
// store read and one on the time-sum add and compare in the shared 32-bit adder.
// busy drops in the strobe cycle, so the next item may be taken then.
// Reset: synchronous, active low; idle phase, counters and times cleared,
// min_interval back to 10. The point store is not cleared; only points
// recorded since are ever read.
module wheel_speed_path_recorder import wspr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_mode,
  input  logic [31:0]       in_time_now,
  input  logic signed [15:0] in_enc_left,
  input  logic signed [15:0] in_enc_right,
  output logic              out_strobe,
  output logic [2:0]        out_status,
  output logic              out_replay_active,
  output logic signed [15:0] out_setpoint_left,
  output logic signed [15:0] out_setpoint_right,
  output logic [CNT_W-1:0]  out_stored_points,
  output logic [31:0]       out_path_duration,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  seq_t        state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, total_r, total_nxt, idx_inc;
  logic [31:0] start_time_r, start_time_nxt, last_time_r, last_time_nxt;
  logic [15:0] prev_l_r, prev_l_nxt, prev_rt_r, prev_rt_nxt;
  logic [31:0] origin_r, origin_nxt, sum_r, sum_nxt, span_r, span_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic [15:0] min_iv_r;
  mode_t       mode_r, mode_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] el_r, el_nxt, er_r, er_nxt;
  logic        active_r, active_nxt;
  logic [15:0] tl_r, tl_nxt, tr_r, tr_nxt;
  logic        strobe_r;
  logic [2:0]  st_out_r;
  logic        act_out_r;
  logic [15:0] tl_out_r, tr_out_r;
  logic [CNT_W-1:0] pts_out_r;
  logic [31:0] dur_out_r;

  alu_op_t     alu_op;
  logic [31:0] alu_a, alu_b, alu_res;
  store_wr_t   wr;
  point_t      rdata;
  phase_t      end_phase;

  wspr_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  wspr_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign idx_inc   = idx_r + CNT_W'(1);
  assign end_phase = (total_r != '0) ? PH_LOADED : PH_IDLE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_DONE;
        if (mode_r == MD_REC_TICK && phase_r == PH_REC &&
            idx_r < CNT_W'(MAX_POINTS)) begin
          state_nxt = S_REC2;
        end
        if (mode_r == MD_PLAY_TICK && phase_r == PH_PLAY && idx_r < total_r) begin
          state_nxt = S_RD;
        end
      end
      S_REC2: state_nxt = S_DONE;
      S_RD:   state_nxt = S_CHK;
      S_CHK: begin
        if (alu_res > elapsed_r || idx_inc >= total_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    alu_op    = ALU_SUB;
    alu_a     = now_r;
    alu_b     = start_time_r;
    wr.en     = 1'b0;
    wr.addr   = idx_r[ADDR_W-1:0];
    wr.data.left  = el_r - prev_l_r;
    wr.data.right = er_r - prev_rt_r;
    wr.data.gap   = gap_r;
    unique case (state_r)
      S_EXEC: begin
        if (mode_r == MD_REC_TICK && idx_r < CNT_W'(MAX_POINTS)) begin
          alu_b = last_time_r;
        end
        if (mode_r == MD_PLAY_TICK) begin
          alu_b = origin_r;
        end
      end
      S_REC2: wr.en = (gap_r >= min_iv_r);
      S_CHK: begin
        alu_op = ALU_ADD;
        alu_a  = sum_r;
        alu_b  = {16'd0, rdata.gap};
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    total_nxt      = total_r;
    start_time_nxt = start_time_r;
    last_time_nxt  = last_time_r;
    prev_l_nxt     = prev_l_r;
    prev_rt_nxt    = prev_rt_r;
    origin_nxt     = origin_r;
    sum_nxt        = sum_r;
    span_nxt       = span_r;
    elapsed_nxt    = elapsed_r;
    gap_nxt        = gap_r;
    mode_nxt       = mode_r;
    now_nxt        = now_r;
    el_nxt         = el_r;
    er_nxt         = er_r;
    active_nxt     = active_r;
    tl_nxt         = tl_r;
    tr_nxt         = tr_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt   = mode_t'(in_mode);
          now_nxt    = in_time_now;
          el_nxt     = in_enc_left;
          er_nxt     = in_enc_right;
          active_nxt = 1'b0;
          tl_nxt     = '0;
          tr_nxt     = '0;
        end
      end
      S_EXEC: begin
        case (mode_r)
          MD_REC_START: begin
            if (phase_r != PH_REC) begin
              phase_nxt      = PH_REC;
              idx_nxt        = '0;
              start_time_nxt = now_r;
              last_time_nxt  = now_r;
              prev_l_nxt     = el_r;
              prev_rt_nxt    = er_r;
              total_nxt      = '0;
              span_nxt       = '0;
            end
          end
          MD_REC_STOP: begin
            if (phase_r == PH_REC) begin
              span_nxt  = alu_res;
              total_nxt = idx_r;
              phase_nxt = PH_SAVED;
            end
          end
          MD_REC_TICK: begin
            if (phase_r == PH_REC) begin
              if (idx_r >= CNT_W'(MAX_POINTS)) begin
                span_nxt  = alu_res;
                total_nxt = idx_r;
                phase_nxt = PH_SAVED;
              end else begin
                gap_nxt = alu_res[15:0];
              end
            end
          end
          MD_PLAY_START: begin
            if ((phase_r == PH_SAVED || phase_r == PH_LOADED) && total_r != '0) begin
              phase_nxt  = PH_PLAY;
              idx_nxt    = '0;
              origin_nxt = now_r;
              sum_nxt    = '0;
            end
          end
          MD_PLAY_STOP: begin
            if (phase_r == PH_PLAY) phase_nxt = end_phase;
          end
          MD_PLAY_TICK: begin
            if (phase_r == PH_PLAY) begin
              if (idx_r >= total_r) begin
                phase_nxt = end_phase;
              end else begin
                elapsed_nxt = alu_res;
              end
            end
          end
          MD_CLEAR: begin
            idx_nxt   = '0;
            total_nxt = '0;
            span_nxt  = '0;
            phase_nxt = PH_IDLE;
          end
          default: ;
        endcase
      end
      S_REC2: begin
        if (gap_r >= min_iv_r) begin
          prev_l_nxt    = el_r;
          prev_rt_nxt   = er_r;
          last_time_nxt = now_r;
          idx_nxt       = idx_inc;
          span_nxt      = alu_res;
        end
      end
      S_CHK: begin
        active_nxt = 1'b1;
        if (alu_res > elapsed_r) begin
          tl_nxt = rdata.left;
          tr_nxt = rdata.right;
        end else begin
          sum_nxt = alu_res;
          idx_nxt = idx_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_IDLE;
      idx_r        <= '0;
      total_r      <= '0;
      start_time_r <= '0;
      last_time_r  <= '0;
      prev_l_r     <= '0;
      prev_rt_r    <= '0;
      origin_r     <= '0;
      sum_r        <= '0;
      span_r       <= '0;
      min_iv_r     <= MIN_IV_RESET;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      total_r      <= total_nxt;
      start_time_r <= start_time_nxt;
      last_time_r  <= last_time_nxt;
      prev_l_r     <= prev_l_nxt;
      prev_rt_r    <= prev_rt_nxt;
      origin_r     <= origin_nxt;
      sum_r        <= sum_nxt;
      span_r       <= span_nxt;
      strobe_r     <= (state_r == S_DONE);
      if (cfg_valid && cfg_ready) begin
        min_iv_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    gap_r     <= gap_nxt;
    mode_r    <= mode_nxt;
    now_r     <= now_nxt;
    el_r      <= el_nxt;
    er_r      <= er_nxt;
    active_r  <= active_nxt;
    tl_r      <= tl_nxt;
    tr_r      <= tr_nxt;
    if (state_r == S_DONE) begin
      st_out_r  <= phase_r;
      act_out_r <= active_r;
      tl_out_r  <= tl_r;
      tr_out_r  <= tr_r;
      pts_out_r <= total_r;
      dur_out_r <= span_r;
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_strobe         = strobe_r;
  assign out_status         = st_out_r;
  assign out_replay_active  = act_out_r;
  assign out_setpoint_left  = tl_out_r;
  assign out_setpoint_right = tr_out_r;
  assign out_stored_points  = pts_out_r;
  assign out_path_duration  = dur_out_r;

`ifndef SYNTHESIS
  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CNT_W'(MAX_POINTS) && total_r <= CNT_W'(MAX_POINTS))
    else $error("point index or total beyond store depth");

  a_write_in_rec: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (phase_r == PH_REC && idx_r < CNT_W'(MAX_POINTS)))
    else $error("store write outside recording");

  a_read_in_play: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (phase_r == PH_PLAY && idx_r < total_r))
    else $error("store read beyond recorded points");
`endif

endmodule

// ----- hdl/wspr_alu.sv -----
`timescale 1ns / 1ps
module wspr_alu import wspr_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);

  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a - b;
    endcase
  end

endmodule

// ----- hdl/wspr_store.sv -----
`timescale 1ns / 1ps
module wspr_store import wspr_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] raddr,
  output point_t            rdata
);

  point_t mem [MAX_POINTS];
  point_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
